[rtl/assert_macros.svh]
// Assertion macros for the colour-table recolouring block.
// Concurrent checks compile in simulation only; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked on every rising edge outside reset
`define LGM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("lgm assertion failed");
// Condition that must never hold outside reset
`define LGM_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("lgm forbidden condition seen");
`else
`define LGM_ASSERT(label, clk, rst_n, prop)
`define LGM_NEVER(label, clk, rst_n, cond)
`endif

`endif

[rtl/lgm_pkg.sv]
// Shared types, constants and arithmetic helpers for the luminance gradient map.
// No dependencies; used by the top level.
package lgm_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int INDEX_W       = $clog2(TABLE_ENTRIES);
	localparam int CHAN_W        = 8;
	localparam int ENTRY_W       = 4 * CHAN_W;
	localparam int WEIGHT_W      = 17;
	localparam int FRAC_W        = 16;
	localparam int PROD_W        = WEIGHT_W + CHAN_W;
	localparam int SUM_W         = PROD_W + 2;
	localparam int LUMA_FULL_W   = SUM_W - FRAC_W;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = WEIGHT_W;
	localparam int IN_DATA_W     = INDEX_W + 4 * CHAN_W;
	localparam int OUT_DATA_W    = 4 * CHAN_W;

	localparam logic [SUM_W-1:0]    ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);
	localparam logic [CHAN_W-1:0]   CHAN_MAX   = '1;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RST   = WEIGHT_W'(13933);
	localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RST = WEIGHT_W'(46871);
	localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RST  = WEIGHT_W'(4732);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RGB_MODE      = 3'd0,
		REG_ALPHA_PRESENT = 3'd1,
		REG_WEIGHT_RED    = 3'd2,
		REG_WEIGHT_GREEN  = 3'd3,
		REG_WEIGHT_BLUE   = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		FUNC_MAP  = 1'b0,
		FUNC_LOAD = 1'b1
	} func_t;

	// a * b / 255, truncated; exact for all 8-bit operands
	function automatic logic [CHAN_W-1:0] scale_alpha(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		logic [2*CHAN_W-1:0] prod;
		logic [2*CHAN_W:0]   acc;
		prod = a * b;
		acc  = {1'b0, prod} + {{(CHAN_W+1){1'b0}}, prod[2*CHAN_W-1:CHAN_W]} + 1'b1;
		return acc[2*CHAN_W-1:CHAN_W];
	endfunction

endpackage

[rtl/luminance_gradient_map.sv]
// Luminance gradient map: each map request takes its pixel's luminance (Q16 weighted RGB,
// rounded and saturated, or the gray byte) as an index into a 256 x 32-bit colour table
// and returns entry bytes 0-2 (RGB) or byte 0 (gray), plus, with alpha present, the entry's
// alpha byte scaled by the source alpha / 255; other bytes are zero. A load (tuser = 1)
// writes one entry and returns nothing. One request is taken every clock unless the result
// stream stalls; a result passes the input register, weight multipliers, sum and saturate,
// table read and alpha scaling. The table is one RAM with one write and one read port;
// entries are undefined until loaded. Depends on lgm_pkg, lgm_ram and assert_macros.svh.
`include "assert_macros.svh"

module luminance_gradient_map (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lgm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lgm_pkg::CFG_DATA_W-1:0]    cfg_data,
	// request stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lgm_pkg::IN_DATA_W-1:0]     s_tdata,   // entry_index, chan0, chan1, chan2, chan3
	input  logic                              s_tuser,   // func
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lgm_pkg::OUT_DATA_W-1:0]    m_tdata    // out0, out1, out2, out3
);

	localparam int CW = lgm_pkg::CHAN_W;
	localparam int IW = lgm_pkg::INDEX_W;

	// configuration registers
	logic                            rgb_mode_q;
	logic                            alpha_present_q;
	logic [lgm_pkg::WEIGHT_W-1:0]    weight_red_q;
	logic [lgm_pkg::WEIGHT_W-1:0]    weight_green_q;
	logic [lgm_pkg::WEIGHT_W-1:0]    weight_blue_q;

	// stage 1: input register
	logic                 v_s1;
	lgm_pkg::func_t       func_s1;
	logic [IW-1:0]        idx_s1;
	logic [CW-1:0]        c0_s1, c1_s1, c2_s1, c3_s1;

	// stage 2: weighted products
	logic                         v_s2;
	lgm_pkg::func_t               func_s2;
	logic [IW-1:0]                idx_s2;
	logic [CW-1:0]                c0_s2, c1_s2, c2_s2, c3_s2;
	logic [lgm_pkg::PROD_W-1:0]   pr_s2, pg_s2, pb_s2;

	// stage 3: table address
	logic                         v_s3;
	lgm_pkg::func_t               func_s3;
	logic [IW-1:0]                addr_s3;
	logic [lgm_pkg::ENTRY_W-1:0]  wdata_s3;
	logic [CW-1:0]                c1_s3, c3_s3;

	// stage 4: table entry (read data held in the RAM)
	logic                         v_s4;
	logic [lgm_pkg::ENTRY_W-1:0]  entry_s4;
	logic [CW-1:0]                c1_s4, c3_s4;

	// result register
	logic                             out_valid_q;
	logic [lgm_pkg::OUT_DATA_W-1:0]   out_data_q;

	logic rdy_out, rdy_s4, rdy_s3, rdy_s2, rdy_s1;
	logic ram_we, ram_re;
	logic [lgm_pkg::SUM_W-1:0]       luma_sum;
	logic [lgm_pkg::LUMA_FULL_W-1:0] luma_full;
	logic [CW-1:0]                   luma;
	logic [CW-1:0]                   alpha_a, alpha_b, alpha_scaled;
	logic [CW-1:0]                   o0, o1, o2, o3;

	// per-stage ready: a stage moves on when empty or when the next one moves
	assign rdy_out  = !out_valid_q || m_tready;
	assign rdy_s4   = !v_s4 || rdy_out;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign cfg_ready = 1'b1;

	// configuration writes; unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_mode_q      <= 1'b1;
			alpha_present_q <= 1'b0;
			weight_red_q    <= lgm_pkg::WEIGHT_RED_RST;
			weight_green_q  <= lgm_pkg::WEIGHT_GREEN_RST;
			weight_blue_q   <= lgm_pkg::WEIGHT_BLUE_RST;
		end else if (cfg_valid) begin
			unique case (lgm_pkg::cfg_reg_t'(cfg_index))
				lgm_pkg::REG_RGB_MODE:      rgb_mode_q      <= cfg_data[0];
				lgm_pkg::REG_ALPHA_PRESENT: alpha_present_q <= cfg_data[0];
				lgm_pkg::REG_WEIGHT_RED:    weight_red_q    <= cfg_data;
				lgm_pkg::REG_WEIGHT_GREEN:  weight_green_q  <= cfg_data;
				lgm_pkg::REG_WEIGHT_BLUE:   weight_blue_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1 <= s_tvalid;
			if (rdy_s2)  v_s2 <= v_s1;
			if (rdy_s3)  v_s3 <= v_s2;
			// loads end at the table write
			if (rdy_s4)  v_s4 <= v_s3 && (func_s3 == lgm_pkg::FUNC_MAP);
			if (rdy_out) out_valid_q <= v_s4;
		end
	end

	// stage 1: capture request
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			func_s1 <= lgm_pkg::func_t'(s_tuser);
			idx_s1  <= s_tdata[IW-1:0];
			c0_s1   <= s_tdata[IW+CW-1:IW];
			c1_s1   <= s_tdata[IW+2*CW-1:IW+CW];
			c2_s1   <= s_tdata[IW+3*CW-1:IW+2*CW];
			c3_s1   <= s_tdata[IW+4*CW-1:IW+3*CW];
		end
	end

	// stage 2: weight each colour channel
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			func_s2 <= func_s1;
			idx_s2  <= idx_s1;
			c0_s2   <= c0_s1;
			c1_s2   <= c1_s1;
			c2_s2   <= c2_s1;
			c3_s2   <= c3_s1;
			pr_s2   <= weight_red_q * c0_s1;
			pg_s2   <= weight_green_q * c1_s1;
			pb_s2   <= weight_blue_q * c2_s1;
		end
	end

	// sum, round half up, drop the fraction and saturate
	always_comb begin
		luma_sum  = lgm_pkg::SUM_W'(pr_s2) + lgm_pkg::SUM_W'(pg_s2)
		          + lgm_pkg::SUM_W'(pb_s2) + lgm_pkg::ROUND_HALF;
		luma_full = luma_sum[lgm_pkg::SUM_W-1:lgm_pkg::FRAC_W];
		if (luma_full > lgm_pkg::LUMA_FULL_W'(lgm_pkg::CHAN_MAX)) begin
			luma = lgm_pkg::CHAN_MAX;
		end else begin
			luma = luma_full[CW-1:0];
		end
	end

	// stage 3: table address and load data
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			func_s3  <= func_s2;
			wdata_s3 <= {c3_s2, c2_s2, c1_s2, c0_s2};
			c1_s3    <= c1_s2;
			c3_s3    <= c3_s2;
			if (func_s2 == lgm_pkg::FUNC_LOAD) begin
				addr_s3 <= idx_s2;
			end else if (rgb_mode_q) begin
				addr_s3 <= luma;
			end else begin
				addr_s3 <= c0_s2;
			end
		end
	end

	// table access: loads write, maps read into stage 4
	assign ram_we = v_s3 && (func_s3 == lgm_pkg::FUNC_LOAD) && rdy_s4;
	assign ram_re = rdy_s4;

	lgm_ram #(
		.WIDTH(lgm_pkg::ENTRY_W),
		.DEPTH(lgm_pkg::TABLE_ENTRIES)
	) u_colour_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s3),
		.wdata(wdata_s3),
		.re   (ram_re),
		.raddr(addr_s3),
		.rdata(entry_s4)
	);

	// stage 4: carry alpha sources beside the table entry
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			c1_s4 <= c1_s3;
			c3_s4 <= c3_s3;
		end
	end

	// select the alpha pair and assemble the result bytes
	always_comb begin
		alpha_a      = rgb_mode_q ? entry_s4[4*CW-1:3*CW] : entry_s4[2*CW-1:CW];
		alpha_b      = rgb_mode_q ? c3_s4 : c1_s4;
		alpha_scaled = lgm_pkg::scale_alpha(alpha_a, alpha_b);
		o0 = entry_s4[CW-1:0];
		o1 = '0;
		o2 = '0;
		o3 = '0;
		if (rgb_mode_q) begin
			o1 = entry_s4[2*CW-1:CW];
			o2 = entry_s4[3*CW-1:2*CW];
			if (alpha_present_q) o3 = alpha_scaled;
		end else if (alpha_present_q) begin
			o1 = alpha_scaled;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (rdy_out) begin
			out_data_q <= {o3, o2, o1, o0};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// a map leaving stage 3 always lands in stage 4
	`LGM_ASSERT(a_map_reaches_s4, clk, arst_n,
		(v_s3 && (func_s3 == lgm_pkg::FUNC_MAP) && rdy_s4) |=> v_s4)
	// a load leaving stage 3 never produces a result
	`LGM_ASSERT(a_load_no_result, clk, arst_n, ram_we |=> !v_s4)
	// a blocked stage 4 keeps its table entry
	`LGM_ASSERT(a_s4_holds, clk, arst_n,
		(v_s4 && !rdy_s4) |=> (v_s4 && $stable(entry_s4)))

endmodule

[rtl/lgm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lgm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[tb/luminance_gradient_map_tb.sv]
// Self-checking bench for the luminance gradient map: loads the colour table, maps pixels
// under several register settings and compares each result with its own predictor.
// Depends on lgm_pkg and the luminance_gradient_map RTL.
module luminance_gradient_map_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASE_REQUESTS = 230;
	localparam int RANDOM_PHASES  = 6;

	// request fields, lowest bits first: entry_index, chan0, chan1, chan2, chan3
	typedef struct packed {
		logic [lgm_pkg::CHAN_W-1:0]  chan3;
		logic [lgm_pkg::CHAN_W-1:0]  chan2;
		logic [lgm_pkg::CHAN_W-1:0]  chan1;
		logic [lgm_pkg::CHAN_W-1:0]  chan0;
		logic [lgm_pkg::INDEX_W-1:0] entry_index;
	} pixel_req_t;

	// result fields, lowest bits first: out0, out1, out2, out3
	typedef struct packed {
		logic [lgm_pkg::CHAN_W-1:0] out3;
		logic [lgm_pkg::CHAN_W-1:0] out2;
		logic [lgm_pkg::CHAN_W-1:0] out1;
		logic [lgm_pkg::CHAN_W-1:0] out0;
	} colour_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [lgm_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [lgm_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [lgm_pkg::IN_DATA_W-1:0]   s_tdata;
	logic                            s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [lgm_pkg::OUT_DATA_W-1:0]  m_tdata;

	// predictor state: colour table and register copies
	logic [lgm_pkg::ENTRY_W-1:0]  colour_lut [lgm_pkg::TABLE_ENTRIES];
	logic                         rgb_on;
	logic                         alpha_on;
	logic [lgm_pkg::WEIGHT_W-1:0] wt_red;
	logic [lgm_pkg::WEIGHT_W-1:0] wt_green;
	logic [lgm_pkg::WEIGHT_W-1:0] wt_blue;

	colour_t pending_colours [$];

	int mismatches;
	int loads_sent;
	int maps_sent;
	int results_seen;
	int settings_used;
	int src_gaps;
	int sink_stalls;
	int sink_hold;

	luminance_gradient_map dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// end the run if handshakes stop
	initial begin
		#4_000_000;
		$display("Timed out waiting on the block at %0t", $time);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic logic [lgm_pkg::CHAN_W-1:0] alpha_scale(
			input logic [lgm_pkg::CHAN_W-1:0] a,
			input logic [lgm_pkg::CHAN_W-1:0] b);
		int unsigned prod;
		prod = a * b;
		return lgm_pkg::CHAN_W'(prod / 255);
	endfunction

	// expected colour for one map request under the current registers
	function automatic colour_t recolour(input pixel_req_t px);
		logic [63:0]                 acc;
		logic [lgm_pkg::INDEX_W-1:0] lum;
		logic [lgm_pkg::ENTRY_W-1:0] entry;
		colour_t                     c;
		c = '0;
		if (rgb_on) begin
			acc = 64'(wt_red) * px.chan0 + 64'(wt_green) * px.chan1
				+ 64'(wt_blue) * px.chan2 + 64'd32768;
			acc = acc >> lgm_pkg::FRAC_W;
			lum = (acc > 64'd255) ? 8'd255 : acc[7:0];
		end else begin
			lum = px.chan0;
		end
		entry = colour_lut[lum];
		c.out0 = entry[7:0];
		if (rgb_on) begin
			c.out1 = entry[15:8];
			c.out2 = entry[23:16];
			if (alpha_on)
				c.out3 = alpha_scale(entry[31:24], px.chan3);
		end else if (alpha_on) begin
			c.out1 = alpha_scale(entry[15:8], px.chan1);
		end
		return c;
	endfunction

	// compare one arrived result with the oldest prediction
	task automatic check_colour(input colour_t got);
		colour_t want;
		results_seen++;
		if (pending_colours.size() == 0) begin
			report($sformatf("result %h arrived with nothing predicted", got));
		end else begin
			want = pending_colours.pop_front();
			if (got.out0 !== want.out0)
				report($sformatf("out0 got %0d expected %0d", got.out0, want.out0));
			if (got.out1 !== want.out1)
				report($sformatf("out1 got %0d expected %0d", got.out1, want.out1));
			if (got.out2 !== want.out2)
				report($sformatf("out2 got %0d expected %0d", got.out2, want.out2));
			if (got.out3 !== want.out3)
				report($sformatf("out3 got %0d expected %0d", got.out3, want.out3));
		end
	endtask

	// result side: check, then choose ready for the next cycle
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1)
				check_colour(colour_t'(m_tdata));
			if (sink_hold > 0) begin
				stall_left = sink_hold;
				sink_hold = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (sink_stalls != 0 && $urandom_range(0, 7) == 0) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (src_gaps == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [lgm_pkg::CHAN_W-1:0] rand_byte();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return lgm_pkg::CHAN_W'($urandom_range(0, 255));
	endfunction

	// offer one request, hold it until taken, then update the predictor
	task automatic send_req(input lgm_pkg::func_t fn, input pixel_req_t px);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= px;
		do @(posedge clk); while (s_tready !== 1'b1);
		if (fn == lgm_pkg::FUNC_LOAD) begin
			colour_lut[px.entry_index] = {px.chan3, px.chan2, px.chan1, px.chan0};
			loads_sent++;
		end else begin
			pending_colours.push_back(recolour(px));
			maps_sent++;
		end
	endtask

	task automatic load_entry(input logic [lgm_pkg::INDEX_W-1:0] idx,
			input logic [lgm_pkg::ENTRY_W-1:0] word);
		pixel_req_t px;
		px = {word, idx};
		send_req(lgm_pkg::FUNC_LOAD, px);
	endtask

	task automatic map_pixel(input logic [lgm_pkg::CHAN_W-1:0] c0,
			input logic [lgm_pkg::CHAN_W-1:0] c1,
			input logic [lgm_pkg::CHAN_W-1:0] c2,
			input logic [lgm_pkg::CHAN_W-1:0] c3);
		pixel_req_t px;
		px = {c3, c2, c1, c0, rand_byte()};
		send_req(lgm_pkg::FUNC_MAP, px);
	endtask

	// drop valid and wait until every predicted result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_colours.size() != 0);
	endtask

	// idle the block fully, loads included, before touching registers
	task automatic quiesce();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all five registers back to back
	task automatic configure(input logic rgb, input logic alpha,
			input logic [lgm_pkg::WEIGHT_W-1:0] wr,
			input logic [lgm_pkg::WEIGHT_W-1:0] wg,
			input logic [lgm_pkg::WEIGHT_W-1:0] wb);
		lgm_pkg::cfg_reg_t              regs [5];
		logic [lgm_pkg::CFG_DATA_W-1:0] vals [5];
		regs = '{lgm_pkg::REG_RGB_MODE, lgm_pkg::REG_ALPHA_PRESENT,
			lgm_pkg::REG_WEIGHT_RED, lgm_pkg::REG_WEIGHT_GREEN, lgm_pkg::REG_WEIGHT_BLUE};
		vals = '{lgm_pkg::CFG_DATA_W'(rgb), lgm_pkg::CFG_DATA_W'(alpha), wr, wg, wb};
		quiesce();
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (cfg_ready !== 1'b1);
			case (regs[i])
				lgm_pkg::REG_RGB_MODE:      rgb_on   = vals[i][0];
				lgm_pkg::REG_ALPHA_PRESENT: alpha_on = vals[i][0];
				lgm_pkg::REG_WEIGHT_RED:    wt_red   = vals[i];
				lgm_pkg::REG_WEIGHT_GREEN:  wt_green = vals[i];
				lgm_pkg::REG_WEIGHT_BLUE:   wt_blue  = vals[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// fill every entry so that no map ever reads an unwritten one
	task automatic test_table_fill();
		logic [lgm_pkg::ENTRY_W-1:0] word;
		src_gaps    = 1;
		sink_stalls = 1;
		for (int i = 0; i < lgm_pkg::TABLE_ENTRIES; i++) begin
			if (i == 0)
				word = '0;
			else if (i == lgm_pkg::TABLE_ENTRIES - 1)
				word = '1;
			else
				word = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
			load_entry(lgm_pkg::INDEX_W'(i), word);
		end
	endtask

	// registers at their reset values: Rec.709 RGB without alpha
	task automatic test_reset_defaults();
		map_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		map_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		map_pixel(8'd255, 8'd0, 8'd0, 8'd0);
		map_pixel(8'd0, 8'd255, 8'd0, 8'd0);
		map_pixel(8'd0, 8'd0, 8'd255, 8'd0);
		map_pixel(8'd128, 8'd64, 8'd32, 8'd255);
	endtask

	// gray pixels with and without alpha; unused channels carry junk
	task automatic test_gray_modes();
		configure(1'b0, 1'b1, lgm_pkg::WEIGHT_RED_RST, lgm_pkg::WEIGHT_GREEN_RST,
			lgm_pkg::WEIGHT_BLUE_RST);
		map_pixel(8'd0, 8'd0, 8'hFF, 8'hFF);
		map_pixel(8'd255, 8'd255, 8'hFF, 8'hFF);
		map_pixel(8'd77, 8'd0, 8'h5A, 8'hA5);
		configure(1'b0, 1'b0, lgm_pkg::WEIGHT_RED_RST, lgm_pkg::WEIGHT_GREEN_RST,
			lgm_pkg::WEIGHT_BLUE_RST);
		map_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		map_pixel(8'd0, 8'hFF, 8'hFF, 8'hFF);
	endtask

	task automatic test_rgb_alpha();
		configure(1'b1, 1'b1, lgm_pkg::WEIGHT_RED_RST, lgm_pkg::WEIGHT_GREEN_RST,
			lgm_pkg::WEIGHT_BLUE_RST);
		map_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		map_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		map_pixel(8'd90, 8'd180, 8'd30, 8'd128);
	endtask

	// zero weights, widest weights with saturation, and unit weights
	task automatic test_weight_extremes();
		configure(1'b1, 1'b0, '0, '0, '0);
		map_pixel(8'd255, 8'd255, 8'd255, 8'd0);
		configure(1'b1, 1'b1, '1, '1, '1);
		map_pixel(8'd1, 8'd0, 8'd0, 8'd200);
		map_pixel(8'd200, 8'd200, 8'd200, 8'd255);
		configure(1'b1, 1'b0, lgm_pkg::WEIGHT_W'(65536), lgm_pkg::WEIGHT_W'(65536),
			lgm_pkg::WEIGHT_W'(65536));
		map_pixel(8'd1, 8'd1, 8'd1, 8'd0);
		map_pixel(8'd255, 8'd255, 8'd255, 8'd0);
	endtask

	// one phase of random registers and mixed load and map requests
	task automatic test_random_phase(input int phase);
		logic [lgm_pkg::WEIGHT_W-1:0] wr, wg, wb;
		logic                         rgb;
		case ($urandom_range(0, 3))
			0, 1: begin
				wr = lgm_pkg::WEIGHT_W'($urandom_range(0, 65536));
				wg = lgm_pkg::WEIGHT_W'($urandom_range(0, 65536 - wr));
				wb = lgm_pkg::WEIGHT_W'(65536 - wr - wg);
			end
			2: begin
				wr = lgm_pkg::WEIGHT_W'($urandom_range(0, 131071));
				wg = lgm_pkg::WEIGHT_W'($urandom_range(0, 131071));
				wb = lgm_pkg::WEIGHT_W'($urandom_range(0, 131071));
			end
			default: begin
				wr = $urandom_range(0, 1) ? '1 : '0;
				wg = $urandom_range(0, 1) ? lgm_pkg::WEIGHT_W'(65536) : '0;
				wb = $urandom_range(0, 1) ? '1 : lgm_pkg::WEIGHT_W'(65536);
			end
		endcase
		rgb = (phase == 0) ? 1'b1 : 1'($urandom_range(0, 1));
		configure(rgb, 1'($urandom_range(0, 1)), wr, wg, wb);
		// first phase and the hold-off phase run without source gaps
		src_gaps    = (phase != 0 && phase != 2);
		sink_stalls = (phase != 0);
		for (int n = 0; n < PHASE_REQUESTS; n++) begin
			if (phase == 2 && n == 40)
				sink_hold = 200;
			if (phase == 4 && n == PHASE_REQUESTS / 2)
				drain_results();
			if ($urandom_range(0, 99) < 15)
				load_entry(lgm_pkg::INDEX_W'($urandom_range(0, 255)),
					{rand_byte(), rand_byte(), rand_byte(), rand_byte()});
			else
				map_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= lgm_pkg::REG_RGB_MODE;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= lgm_pkg::FUNC_MAP;
		rgb_on      = 1'b1;
		alpha_on    = 1'b0;
		wt_red      = lgm_pkg::WEIGHT_RED_RST;
		wt_green    = lgm_pkg::WEIGHT_GREEN_RST;
		wt_blue     = lgm_pkg::WEIGHT_BLUE_RST;
		mismatches  = 0;
		loads_sent  = 0;
		maps_sent   = 0;
		results_seen = 0;
		settings_used = 1;
		src_gaps    = 0;
		sink_stalls = 0;
		sink_hold   = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_fill();
		test_reset_defaults();
		test_gray_modes();
		test_rgb_alpha();
		test_weight_extremes();
		for (int p = 0; p < RANDOM_PHASES; p++)
			test_random_phase(p);

		quiesce();
		$display("Covered %0d table loads and %0d pixel maps over %0d register settings,",
			loads_sent, maps_sent, settings_used);
		$display("with a long result hold-off and a full drain; %0d results checked.",
			results_seen);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
